// ===== design/clsp_pkg.sv =====
// Shared types and constants for the charge limit setpoint policy block.
`timescale 1ns / 1ps

package clsp_pkg;

  localparam int unsigned LevelW    = 7;
  localparam int unsigned TolW      = 8;
  localparam int unsigned MsW       = 16;
  localparam int unsigned VoltW     = 24;
  localparam int unsigned CurReqW   = 25;
  localparam int unsigned CurW      = 24;
  localparam int unsigned QuotW     = 15;
  localparam int unsigned FactorW   = 10;
  localparam int unsigned RecipW    = 25;
  localparam int unsigned RecipSh   = 34;
  localparam int unsigned ProdW     = CurW + RecipW;
  localparam int unsigned ScaleW    = QuotW + FactorW;

  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 72;
  localparam int unsigned AddrW     = 5;
  localparam int unsigned ApbDataW  = 32;

  // ceil(2^34 / 1000): exact floor(x / 1000) for any 24-bit x
  localparam logic [RecipW-1:0]  RECIP_1000  = 25'd17179870;
  localparam logic [FactorW-1:0] PER_MILLE   = 10'd1000;
  localparam logic [TolW-1:0]    TOL_MAX     = 8'd250;

  localparam logic [LevelW-1:0] DEF_STOP_LEVEL  = 7'd100;
  localparam logic [LevelW-1:0] DEF_START_LEVEL = 7'd0;
  localparam logic [MsW-1:0]    DEF_CC_MS       = 16'd30000;
  localparam logic [MsW-1:0]    DEF_CV_MS       = 16'd2000;
  localparam logic [MsW-1:0]    RETRY_MS        = 16'd1000;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_STOP_LEVEL  = 3'd0;
  localparam logic [2:0] REG_START_LEVEL = 3'd1;
  localparam logic [2:0] REG_CUR_TOL     = 3'd2;
  localparam logic [2:0] REG_CC_MS       = 3'd3;
  localparam logic [2:0] REG_CV_MS       = 3'd4;

  localparam logic [1:0] SRC_ABSENT = 2'd0;

  localparam logic [2:0] ST_UNKNOWN      = 3'd0;
  localparam logic [2:0] ST_CHARGING     = 3'd1;
  localparam logic [2:0] ST_DISCHARGING  = 3'd2;
  localparam logic [2:0] ST_NOT_CHARGING = 3'd3;
  localparam logic [2:0] ST_FULL         = 3'd4;

  typedef enum logic [1:0] {
    OUT_RESCHED = 2'd0,
    OUT_RETRY   = 2'd1,
    OUT_NO_SRC  = 2'd2,
    OUT_STOP    = 2'd3
  } outcome_e;

  typedef struct packed {
    logic [LevelW-1:0] stop_level;
    logic [LevelW-1:0] start_level;
    logic [TolW-1:0]   current_tolerance;
    logic [MsW-1:0]    cc_interval_ms;
    logic [MsW-1:0]    cv_interval_ms;
  } clsp_cfg_t;

  typedef struct packed {
    logic [1:0]                usb_source;
    logic [1:0]                wireless_source;
    logic [LevelW-1:0]         battery_percent;
    logic                      percent_error;
    logic [2:0]                charger_status;
    logic                      status_error;
    logic                      cc_phase;
    logic                      battery_report_error;
    logic signed [VoltW-1:0]   request_voltage_uv;
    logic signed [CurReqW-1:0] request_current_ua;
    logic                      write_fail;
  } clsp_item_t;

  typedef struct packed {
    outcome_e                outcome;
    logic                    charge_disable;
    logic                    input_suspend;
    logic                    setpoint_write;
    logic [CurW-1:0]         current_limit_ua;
    logic signed [VoltW-1:0] voltage_limit_uv;
    logic [MsW-1:0]          next_run_ms;
  } clsp_result_t;

endpackage

// ===== design/clsp_regs.sv =====
// APB configuration registers of the setpoint policy.
`timescale 1ns / 1ps

module clsp_regs
  import clsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output clsp_cfg_t           cfg_o
);

  clsp_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stop_level        <= DEF_STOP_LEVEL;
      cfg_q.start_level       <= DEF_START_LEVEL;
      cfg_q.current_tolerance <= '0;
      cfg_q.cc_interval_ms    <= DEF_CC_MS;
      cfg_q.cv_interval_ms    <= DEF_CV_MS;
    end else if (wr_en) begin
      unique case (idx)
        REG_STOP_LEVEL:  cfg_q.stop_level        <= pwdata[LevelW-1:0];
        REG_START_LEVEL: cfg_q.start_level       <= pwdata[LevelW-1:0];
        REG_CUR_TOL:     cfg_q.current_tolerance <= pwdata[TolW-1:0];
        REG_CC_MS:       cfg_q.cc_interval_ms    <= pwdata[MsW-1:0];
        REG_CV_MS:       cfg_q.cv_interval_ms    <= pwdata[MsW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STOP_LEVEL:  prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.stop_level};
      REG_START_LEVEL: prdata = {{(ApbDataW-LevelW){1'b0}}, cfg_q.start_level};
      REG_CUR_TOL:     prdata = {{(ApbDataW-TolW){1'b0}}, cfg_q.current_tolerance};
      REG_CC_MS:       prdata = {{(ApbDataW-MsW){1'b0}}, cfg_q.cc_interval_ms};
      REG_CV_MS:       prdata = {{(ApbDataW-MsW){1'b0}}, cfg_q.cv_interval_ms};
      default:         prdata = '0;
    endcase
  end

endmodule

// ===== design/clsp_curr.sv =====
// Current scaling stages: divide by 1000, then multiply by (1000 - tolerance).
`timescale 1ns / 1ps

module clsp_curr
  import clsp_pkg::*;
(
  input  logic            clk_i,
  input  logic            en_div_i,
  input  logic            en_scale_i,
  input  logic [TolW-1:0] tol_i,
  input  clsp_item_t      item_i,
  output clsp_item_t      item_o,
  output logic [CurW-1:0] cc_o
);

  clsp_item_t         div_item_q;
  logic [QuotW-1:0]   quot_q;
  logic [QuotW-1:0]   quot_d;
  logic [ProdW-1:0]   prod;
  clsp_item_t         scale_item_q;
  logic [CurW-1:0]    cc_q;
  logic [TolW-1:0]    tol_lim;
  logic [FactorW-1:0] factor;
  logic [ScaleW-1:0]  scaled;

  // only non-negative requests reach the setpoint path, so 24 bits suffice
  assign prod   = item_i.request_current_ua[CurW-1:0] * RECIP_1000;
  assign quot_d = prod[RecipSh +: QuotW];

  assign tol_lim = (tol_i > TOL_MAX) ? TOL_MAX : tol_i;
  assign factor  = PER_MILLE - {{(FactorW-TolW){1'b0}}, tol_lim};
  assign scaled  = quot_q * factor;

  always_ff @(posedge clk_i) begin
    if (en_div_i) begin
      div_item_q <= item_i;
      quot_q     <= quot_d;
    end
    if (en_scale_i) begin
      scale_item_q <= div_item_q;
      cc_q         <= scaled[CurW-1:0];
    end
  end

  assign item_o = scale_item_q;
  assign cc_o   = cc_q;

endmodule

// ===== design/clsp_policy.sv =====
// Policy state (hysteresis, last setpoints) and the result register.
`timescale 1ns / 1ps

module clsp_policy
  import clsp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  clsp_cfg_t       cfg_i,
  input  clsp_item_t      item_i,
  input  logic [CurW-1:0] cc_i,
  output clsp_result_t    result_o
);

  logic                      stopped_q, stopped_d;
  logic                      lower_q, lower_d;
  logic                      dis_q, dis_d;
  logic                      sus_q, sus_d;
  logic                      sus_cmd_q, sus_cmd_d;
  logic signed [VoltW-1:0]   last_v_q, last_v_d;
  logic signed [CurReqW-1:0] last_c_q, last_c_d;
  clsp_result_t              res_q, res_d;

  logic                    src_err, no_src, bypass, lv_ok, dis, sus, bad, change;
  logic [MsW-1:0]          cc_ms, cv_ms, ivl;
  logic signed [VoltW-1:0] fv;

  always_comb begin
    src_err = item_i.usb_source[1] | item_i.wireless_source[1];
    no_src  = (item_i.usb_source == SRC_ABSENT) && (item_i.wireless_source == SRC_ABSENT);
    bypass  = (cfg_i.stop_level == DEF_STOP_LEVEL) && (cfg_i.start_level == DEF_START_LEVEL);
    lv_ok   = (cfg_i.stop_level > cfg_i.start_level) && (cfg_i.stop_level <= DEF_STOP_LEVEL);
    cc_ms   = (cfg_i.cc_interval_ms == '0) ? DEF_CC_MS : cfg_i.cc_interval_ms;
    cv_ms   = (cfg_i.cv_interval_ms == '0) ? DEF_CV_MS : cfg_i.cv_interval_ms;
    fv      = item_i.request_voltage_uv[VoltW-1] ? last_v_q : item_i.request_voltage_uv;
    change  = (fv != last_v_q) || ({1'b0, cc_i} != last_c_q);
    bad     = (item_i.request_current_ua != '0) &&
              (item_i.request_voltage_uv[VoltW-1] || item_i.request_current_ua[CurReqW-1]);

    unique case (item_i.charger_status)
      ST_FULL:         ivl = cc_ms;
      ST_CHARGING:     ivl = item_i.cc_phase ? cc_ms : cv_ms;
      ST_NOT_CHARGING: ivl = cv_ms;
      ST_DISCHARGING:  ivl = '0;
      default:         ivl = cv_ms;
    endcase

    // start/stop hysteresis
    lower_d = lower_q;
    dis     = 1'b0;
    if (!bypass && lv_ok) begin
      if (lower_q && (cfg_i.stop_level <= item_i.battery_percent)) begin
        lower_d = 1'b0;
        dis     = 1'b1;
      end else if (!lower_q && (cfg_i.start_level < item_i.battery_percent)) begin
        dis = 1'b1;
      end else if (!lower_q) begin
        lower_d = 1'b1;
      end
    end
    sus = dis && (item_i.battery_percent > cfg_i.stop_level);

    stopped_d = stopped_q;
    dis_d     = dis_q;
    sus_d     = sus_q;
    sus_cmd_d = sus_cmd_q;
    last_v_d  = last_v_q;
    last_c_d  = last_c_q;

    res_d.outcome          = OUT_RETRY;
    res_d.setpoint_write   = 1'b0;
    res_d.current_limit_ua = '0;
    res_d.voltage_limit_uv = '0;
    res_d.next_run_ms      = RETRY_MS;

    if (src_err) begin
      lower_d = lower_q;
    end else if (no_src) begin
      lower_d            = 1'b1;
      stopped_d          = 1'b1;
      dis_d              = 1'b0;
      sus_d              = 1'b0;
      last_v_d           = '1;
      last_c_d           = '1;
      res_d.outcome      = OUT_NO_SRC;
      res_d.next_run_ms  = '0;
    end else begin
      stopped_d = 1'b0;
      if (item_i.percent_error) begin
        lower_d = lower_q;
      end else begin
        dis_d = dis;
        sus_d = sus;
        if (sus != sus_q) sus_cmd_d = sus;
        if (dis || sus) begin
          if (!item_i.write_fail) begin
            res_d.setpoint_write   = 1'b1;
            res_d.voltage_limit_uv = last_v_q;
            res_d.outcome          = OUT_RESCHED;
            res_d.next_run_ms      = cc_ms;
          end
        end else if (!item_i.status_error && !item_i.battery_report_error && !bad) begin
          if (!(change && item_i.write_fail)) begin
            if (change) begin
              res_d.setpoint_write   = 1'b1;
              res_d.current_limit_ua = cc_i;
              res_d.voltage_limit_uv = fv;
              last_v_d               = fv;
              last_c_d               = {1'b0, cc_i};
            end
            if (ivl != '0) begin
              res_d.outcome     = OUT_RESCHED;
              res_d.next_run_ms = ivl;
            end else begin
              // discharging: state reset after any write
              lower_d           = 1'b1;
              stopped_d         = 1'b1;
              dis_d             = 1'b0;
              sus_d             = 1'b0;
              last_v_d          = '1;
              last_c_d          = '1;
              res_d.outcome     = OUT_STOP;
              res_d.next_run_ms = '0;
            end
          end
        end
      end
    end

    res_d.charge_disable = stopped_d | dis_d;
    res_d.input_suspend  = sus_cmd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q <= 1'b1;
      lower_q   <= 1'b1;
      dis_q     <= 1'b0;
      sus_q     <= 1'b0;
      sus_cmd_q <= 1'b0;
      last_v_q  <= '1;
      last_c_q  <= '1;
    end else if (load_i) begin
      stopped_q <= stopped_d;
      lower_q   <= lower_d;
      dis_q     <= dis_d;
      sus_q     <= sus_d;
      sus_cmd_q <= sus_cmd_d;
      last_v_q  <= last_v_d;
      last_c_q  <= last_c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) res_q <= res_d;
  end

  assign result_o = res_q;

endmodule

// ===== design/charge_limit_setpoint_policy.sv =====
// Top level of the charge limit setpoint policy block.
// Usage:
//   One beat on the s_axis channel is one run of the charging policy; each run
//   yields exactly one result beat on the m_axis channel, in order.
//   Configuration goes through the APB port (stop/start level, tolerance,
//   cc/cv intervals at byte addresses 0x00..0x10); write it only while idle.
// Stages and throughput:
//   Four stages: input register, divide-by-1000 multiply, tolerance scale
//   multiply, policy decision into the result register. One beat per cycle
//   is sustained while m_axis_tready stays high. The two multipliers set the
//   stage count.
// Stall:
//   Each stage advances when the one after it is free or draining, so
//   bubbles collapse; with m_axis_tready low the pipe fills and
//   s_axis_tready drops only once all four stages hold a beat.
// Reset:
//   rst_ni clears every stage valid, loads the register defaults and puts
//   the policy state in its stopped state (charging disabled, no setpoints).
`timescale 1ns / 1ps

module charge_limit_setpoint_policy
  import clsp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // usb_source, wireless_source, battery_percent, percent_error, charger_status,
  // status_error, cc_phase, battery_report_error, request_voltage_uv,
  // request_current_ua, write_fail, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // outcome, charge_disable, input_suspend, setpoint_write, current_limit_ua,
  // voltage_limit_uv, next_run_ms, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [AddrW-1:0]    paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  clsp_cfg_t    cfg;
  clsp_item_t   in_item, in_q, sc_item;
  logic [CurW-1:0] cc;
  clsp_result_t res;
  logic v_in_q, v_div_q, v_sc_q, v_out_q;
  logic rdy_div, rdy_sc, rdy_out, s_fire;

  assign in_item.usb_source           = s_axis_tdata[1:0];
  assign in_item.wireless_source      = s_axis_tdata[3:2];
  assign in_item.battery_percent      = s_axis_tdata[10:4];
  assign in_item.percent_error        = s_axis_tdata[11];
  assign in_item.charger_status       = s_axis_tdata[14:12];
  assign in_item.status_error         = s_axis_tdata[15];
  assign in_item.cc_phase             = s_axis_tdata[16];
  assign in_item.battery_report_error = s_axis_tdata[17];
  assign in_item.request_voltage_uv   = s_axis_tdata[41:18];
  assign in_item.request_current_ua   = s_axis_tdata[66:42];
  assign in_item.write_fail           = s_axis_tdata[67];

  assign rdy_out       = !v_out_q || m_axis_tready;
  assign rdy_sc        = !v_sc_q || rdy_out;
  assign rdy_div       = !v_div_q || rdy_sc;
  assign s_axis_tready = !v_in_q || rdy_div;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q  <= 1'b0;
      v_div_q <= 1'b0;
      v_sc_q  <= 1'b0;
      v_out_q <= 1'b0;
    end else begin
      if (s_axis_tready) v_in_q  <= s_axis_tvalid;
      if (rdy_div)       v_div_q <= v_in_q;
      if (rdy_sc)        v_sc_q  <= v_div_q;
      if (rdy_out)       v_out_q <= v_sc_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) in_q <= in_item;
  end

  clsp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  clsp_curr u_curr (
    .clk_i      (clk_i),
    .en_div_i   (v_in_q && rdy_div),
    .en_scale_i (v_div_q && rdy_sc),
    .tol_i      (cfg.current_tolerance),
    .item_i     (in_q),
    .item_o     (sc_item),
    .cc_o       (cc)
  );

  clsp_policy u_policy (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (v_sc_q && rdy_out),
    .cfg_i    (cfg),
    .item_i   (sc_item),
    .cc_i     (cc),
    .result_o (res)
  );

  assign m_axis_tvalid = v_out_q;
  assign m_axis_tdata  = {3'b000, res.next_run_ms, res.voltage_limit_uv,
                          res.current_limit_ua, res.setpoint_write,
                          res.input_suspend, res.charge_disable, res.outcome};

  a_no_src_reset : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.outcome == OUT_NO_SRC) |->
      (res.charge_disable && res.next_run_ms == '0 && !res.setpoint_write))
    else $error("no-source result without state reset");

  a_write_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res.setpoint_write) |->
      (res.outcome == OUT_RESCHED || res.outcome == OUT_STOP))
    else $error("setpoint written on a failing run");

  a_full_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v_in_q && v_div_q && v_sc_q && v_out_q && !m_axis_tready))
    else $error("input stalled with room in the pipeline");

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking bench for the charge limit setpoint policy block.
`timescale 1ns / 1ps

module tb_top
  import clsp_pkg::*;
;

  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned PHASES         = 9;
  localparam int unsigned RUNS_PER_PHASE = 180;

  localparam logic [1:0] SRC_ON  = 2'd1;
  localparam logic [1:0] SRC_ERR = 2'd2;
  localparam logic [2:0] ST_UNDEF_FIRST = 3'd5;
  localparam logic [2:0] ST_UNDEF_LAST  = 3'd7;

  // Predicts one result per policy run and checks results in order.
  class policy_board;
    logic [LevelW-1:0] stop_lvl, start_lvl;
    logic [TolW-1:0]   tol;
    logic [MsW-1:0]    cc_ms, cv_ms;
    bit                stopped, lower_reached, disabled_now, suspended_now, suspend_cmd;
    int                last_v, last_c;
    clsp_result_t      pending_outcomes[$];
    int unsigned       mismatches, results_seen;

    function new();
      stop_lvl    = DEF_STOP_LEVEL;
      start_lvl   = DEF_START_LEVEL;
      tol         = '0;
      cc_ms       = DEF_CC_MS;
      cv_ms       = DEF_CV_MS;
      suspend_cmd = 1'b0;
      clear_policy();
    endfunction

    function void clear_policy();
      last_v        = -1;
      last_c        = -1;
      disabled_now  = 1'b0;
      suspended_now = 1'b0;
      lower_reached = 1'b1;
      stopped       = 1'b1;
    endfunction

    function void set_reg(logic [2:0] idx, logic [ApbDataW-1:0] val);
      case (idx)
        REG_STOP_LEVEL:  stop_lvl  = val[LevelW-1:0];
        REG_START_LEVEL: start_lvl = val[LevelW-1:0];
        REG_CUR_TOL:     tol       = val[TolW-1:0];
        REG_CC_MS:       cc_ms     = val[MsW-1:0];
        REG_CV_MS:       cv_ms     = val[MsW-1:0];
        default: ;
      endcase
    endfunction

    // start/stop level hysteresis; levels 0/100 bypass it entirely
    function bit hold_charge(logic [LevelW-1:0] soc);
      int up, lo;
      up = stop_lvl;
      lo = start_lvl;
      if (stop_lvl == DEF_STOP_LEVEL && start_lvl == DEF_START_LEVEL) return 1'b0;
      if (up > lo && up <= DEF_STOP_LEVEL) begin
        if (lower_reached && up <= soc) begin
          lower_reached = 1'b0;
          return 1'b1;
        end
        if (!lower_reached && lo < soc) return 1'b1;
        lower_reached = 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_run(clsp_item_t r);
      clsp_result_t want;
      int  rv, rc, fv, cur, ivl, cc_iv, cv_iv, tolc, next, w_cur, w_volt;
      bit  dis, sus, bad, wrote, ok;
      want.outcome = OUT_RETRY;
      next   = RETRY_MS;
      wrote  = 1'b0;
      w_cur  = 0;
      w_volt = 0;
      cc_iv  = (cc_ms != 0) ? cc_ms : DEF_CC_MS;
      cv_iv  = (cv_ms != 0) ? cv_ms : DEF_CV_MS;
      rv     = $signed(r.request_voltage_uv);
      rc     = $signed(r.request_current_ua);
      if (r.usb_source >= SRC_ERR || r.wireless_source >= SRC_ERR) begin
        // source read error: plain retry, state untouched
      end else if (r.usb_source == SRC_ABSENT && r.wireless_source == SRC_ABSENT) begin
        clear_policy();
        want.outcome = OUT_NO_SRC;
        next = 0;
      end else begin
        stopped = 1'b0;
        if (!r.percent_error) begin
          dis = hold_charge(r.battery_percent);
          sus = dis && (r.battery_percent > stop_lvl);
          disabled_now = dis;
          if (sus != suspended_now) suspend_cmd = sus;
          suspended_now = sus;
          if (dis || sus) begin
            if (!r.write_fail) begin
              wrote  = 1'b1;
              w_volt = last_v;
              want.outcome = OUT_RESCHED;
              next = cc_iv;
            end
          end else if (!r.status_error && !r.battery_report_error) begin
            case (r.charger_status)
              ST_FULL:         ivl = cc_iv;
              ST_CHARGING:     ivl = r.cc_phase ? cc_iv : cv_iv;
              ST_NOT_CHARGING: ivl = cv_iv;
              ST_DISCHARGING:  ivl = 0;
              default:         ivl = cv_iv;
            endcase
            bad = (rc != 0) && (rv < 0 || rc < 0);
            if (!bad) begin
              tolc = (tol > TOL_MAX) ? TOL_MAX : tol;
              fv   = (rv < 0) ? last_v : rv;
              cur  = (rc / 1000) * (1000 - tolc);
              ok   = 1'b1;
              if (fv != last_v || cur != last_c) begin
                if (r.write_fail) begin
                  ok = 1'b0;
                end else begin
                  wrote  = 1'b1;
                  w_cur  = cur;
                  w_volt = fv;
                  last_c = cur;
                  last_v = fv;
                end
              end
              if (ok) begin
                if (ivl != 0) begin
                  want.outcome = OUT_RESCHED;
                  next = ivl;
                end else begin
                  clear_policy();
                  want.outcome = OUT_STOP;
                  next = 0;
                end
              end
            end
          end
        end
      end
      want.charge_disable   = stopped || disabled_now;
      want.input_suspend    = suspend_cmd;
      want.setpoint_write   = wrote;
      want.current_limit_ua = w_cur[CurW-1:0];
      want.voltage_limit_uv = w_volt[VoltW-1:0];
      want.next_run_ms      = next[MsW-1:0];
      pending_outcomes.push_back(want);
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      $display("%0t: %s expected 0x%0h got 0x%0h", $time, what, want, got);
    endfunction

    function void check_result(logic [OutDataW-1:0] d);
      clsp_result_t want;
      string        tag;
      if (pending_outcomes.size() == 0) begin
        report("result beat with no run pending, low word", 32'd0, d[31:0]);
        return;
      end
      want = pending_outcomes.pop_front();
      tag  = $sformatf("result %0d", results_seen);
      results_seen++;
      if (d[1:0] != want.outcome)
        report({tag, " outcome"}, 32'(want.outcome), 32'(d[1:0]));
      if (d[2] != want.charge_disable)
        report({tag, " charge_disable"}, 32'(want.charge_disable), 32'(d[2]));
      if (d[3] != want.input_suspend)
        report({tag, " input_suspend"}, 32'(want.input_suspend), 32'(d[3]));
      if (d[4] != want.setpoint_write)
        report({tag, " setpoint_write"}, 32'(want.setpoint_write), 32'(d[4]));
      if (d[28:5] != want.current_limit_ua)
        report({tag, " current_limit_ua"}, 32'(want.current_limit_ua), 32'(d[28:5]));
      if (d[52:29] != want.voltage_limit_uv)
        report({tag, " voltage_limit_uv"}, 32'(want.voltage_limit_uv), 32'(d[52:29]));
      if (d[68:53] != want.next_run_ms)
        report({tag, " next_run_ms"}, 32'(want.next_run_ms), 32'(d[68:53]));
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                psel          = 1'b0;
  logic                penable       = 1'b0;
  logic                pwrite        = 1'b0;
  logic [AddrW-1:0]    paddr         = '0;
  logic [ApbDataW-1:0] pwdata        = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  policy_board board;
  int unsigned runs_sent   = 0;
  int unsigned cycle_count = 0;
  int          burst_left  = 1;
  int          soc_walk    = 50;
  int          hold_v      = 4200000;
  int          hold_c      = 2000000;

  charge_limit_setpoint_policy uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
  end

  // sink: random ready patterns, plus two long hold-offs so the pipe backs up
  initial begin : sink_pattern
    int unsigned seg_len, mode, hold_at, k;
    hold_at = 300;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (runs_sent >= hold_at) begin
        hold_at = (hold_at < 1000) ? 1000 : 32'hFFFF_FFFF;
        m_axis_tready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end
      mode    = $urandom_range(0, 3);
      seg_len = $urandom_range(10, 60);
      for (k = 0; k < seg_len; k++) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= 1'($urandom_range(0, 1));
          2: m_axis_tready <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready <= (k % 5) != 0;
        endcase
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [InDataW-1:0] pack_run(clsp_item_t r);
    return {4'b0, r.write_fail, r.request_current_ua, r.request_voltage_uv,
            r.battery_report_error, r.cc_phase, r.status_error, r.charger_status,
            r.percent_error, r.battery_percent, r.wireless_source, r.usb_source};
  endfunction

  function automatic clsp_item_t nominal_run();
    clsp_item_t r;
    r.usb_source           = SRC_ON;
    r.wireless_source      = SRC_ABSENT;
    r.battery_percent      = 7'd50;
    r.percent_error        = 1'b0;
    r.charger_status       = ST_CHARGING;
    r.status_error         = 1'b0;
    r.cc_phase             = 1'b1;
    r.battery_report_error = 1'b0;
    r.request_voltage_uv   = 24'sd4200000;
    r.request_current_ua   = 25'sd2000000;
    r.write_fail           = 1'b0;
    return r;
  endfunction

  // mostly well-formed runs: soc walks, requests repeat so "no change" is common
  function automatic clsp_item_t random_run();
    clsp_item_t  r;
    int unsigned pick;
    r = nominal_run();
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      r.usb_source      = SRC_ABSENT;
      r.wireless_source = SRC_ABSENT;
    end else if (pick < 9) begin
      r.usb_source      = 2'($urandom_range(0, 3));
      r.wireless_source = 2'($urandom_range(0, 3));
      if (r.usb_source < SRC_ERR && r.wireless_source < SRC_ERR)
        r.usb_source = SRC_ERR | 2'($urandom_range(0, 1));
    end else if (pick < 60) begin
      r.usb_source      = SRC_ON;
      r.wireless_source = SRC_ABSENT;
    end else if (pick < 75) begin
      r.usb_source      = SRC_ABSENT;
      r.wireless_source = SRC_ON;
    end else begin
      r.usb_source      = SRC_ON;
      r.wireless_source = SRC_ON;
    end

    if ($urandom_range(0, 19) == 0) soc_walk = $urandom_range(0, 127);
    else soc_walk = soc_walk + int'($urandom_range(0, 12)) - 6;
    if (soc_walk < 0) soc_walk = 0;
    if (soc_walk > 127) soc_walk = 127;
    r.battery_percent = soc_walk[LevelW-1:0];

    r.percent_error        = ($urandom_range(0, 99) < 4);
    r.status_error         = ($urandom_range(0, 99) < 4);
    r.battery_report_error = ($urandom_range(0, 99) < 4);
    r.write_fail           = ($urandom_range(0, 99) < 5);
    r.cc_phase             = 1'($urandom_range(0, 1));

    pick = $urandom_range(0, 99);
    if (pick < 50) r.charger_status = ST_CHARGING;
    else if (pick < 62) r.charger_status = ST_FULL;
    else if (pick < 72) r.charger_status = ST_NOT_CHARGING;
    else if (pick < 80) r.charger_status = ST_UNKNOWN;
    else if (pick < 86) r.charger_status = ST_DISCHARGING;
    else if (pick < 90) r.charger_status = 3'($urandom_range(ST_UNDEF_FIRST, ST_UNDEF_LAST));
    else r.charger_status = ST_CHARGING;

    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) hold_v = $urandom_range(3400000, 4500000);
      else if (pick < 85) hold_v = $signed(24'($urandom()));
      else if (pick < 95) hold_v = -1;
      else hold_v = 0;
    end
    if ($urandom_range(0, 3) == 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) hold_c = $urandom_range(0, 3000000);
      else if (pick < 75) hold_c = 0;
      else if (pick < 90) hold_c = $signed(25'($urandom()));
      else hold_c = $urandom_range(16000000, 16777215);
    end
    r.request_voltage_uv = hold_v[VoltW-1:0];
    r.request_current_ua = hold_c[CurReqW-1:0];
    return r;
  endfunction

  // offer one run; bursts of random length with random gaps after them
  task automatic send_run(input clsp_item_t r);
    int unsigned gap;
    s_axis_tdata  <= pack_run(r);
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_run(r);
    runs_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (board.pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // write, then read back; upper pwdata bits carry junk the register must drop
  task automatic apb_write_reg(input logic [2:0] idx, input logic [ApbDataW-1:0] val);
    logic [ApbDataW-1:0] mask, got;
    mask = (idx == REG_CUR_TOL) ? 32'hFF :
           (idx == REG_CC_MS || idx == REG_CV_MS) ? 32'hFFFF : 32'h7F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (val & mask) | ($urandom() & ~mask);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.set_reg(idx, val & mask);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if ((got & mask) != (val & mask))
      board.report($sformatf("register %0d readback", idx), val & mask, got & mask);
  endtask

  task automatic load_setting(input int stop, input int start, input int tol,
                              input int cc, input int cv);
    apb_write_reg(REG_STOP_LEVEL, stop);
    apb_write_reg(REG_START_LEVEL, start);
    apb_write_reg(REG_CUR_TOL, tol);
    apb_write_reg(REG_CC_MS, cc);
    apb_write_reg(REG_CV_MS, cv);
  endtask

  initial begin : stimulus
    clsp_item_t r;
    int         stop;
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        wait_idle();
        case (phase)
          1: load_setting(80, 60, 255, 0, 0);
          2: load_setting(100, 0, 250, 65535, 1);
          3: load_setting(50, 50, 0, 1, 65535);
          4: load_setting(120, 10, 100, 500, 300);
          5: load_setting(1, 0, 7, 65535, 65535);
          6: load_setting(100, 99, 251, 1000, 40000);
          7: load_setting(127, 127, 128, 0, 1);
          default: begin
            stop = $urandom_range(1, 100);
            load_setting(stop, $urandom_range(0, stop - 1), $urandom_range(0, 255),
                         $urandom_range(0, 65535), $urandom_range(0, 65535));
          end
        endcase
      end

      if (phase == 0) begin
        // reset levels: hysteresis bypassed
        r = nominal_run();
        send_run(r);                              // first setpoints after reset
        send_run(r);                              // unchanged: nothing written
        r.request_current_ua = '0;
        r.request_voltage_uv = -24'sd1;
        send_run(r);                              // zero current keeps last voltage
        r.request_current_ua = 25'sd1000;
        send_run(r);                              // negative voltage: error
        r = nominal_run();
        r.request_current_ua = -25'sd1;
        send_run(r);                              // negative current: error
        r = nominal_run();
        r.battery_percent    = 7'd127;
        r.charger_status     = ST_FULL;
        r.request_voltage_uv = 24'sd8388607;
        r.request_current_ua = 25'sd16777215;
        r.usb_source         = SRC_ON;
        r.wireless_source    = SRC_ON;
        send_run(r);                              // field maxima, percent past 100
        r.charger_status = ST_UNDEF_LAST;
        send_run(r);
        r.charger_status = ST_UNKNOWN;
        send_run(r);
        r.charger_status = ST_NOT_CHARGING;
        send_run(r);
        r = nominal_run();
        r.request_current_ua = 25'sd1234567;
        r.write_fail         = 1'b1;
        send_run(r);                              // failed write keeps old setpoints
        r = nominal_run();
        r.percent_error = 1'b1;
        send_run(r);
        r = nominal_run();
        r.status_error = 1'b1;
        send_run(r);
        r = nominal_run();
        r.battery_report_error = 1'b1;
        send_run(r);
        r = nominal_run();
        r.usb_source = SRC_ERR;
        send_run(r);
        r.usb_source      = SRC_ABSENT;
        r.wireless_source = SRC_ERR | 2'd1;
        send_run(r);                              // code 3 acts as read error
        r = nominal_run();
        r.usb_source      = SRC_ABSENT;
        r.wireless_source = SRC_ON;
        send_run(r);
        r.charger_status     = ST_DISCHARGING;
        r.request_current_ua = 25'sd777000;
        send_run(r);                              // write, then stop reset
        r = nominal_run();
        r.usb_source = SRC_ABSENT;
        send_run(r);                              // no source
      end else if (phase == 1) begin
        // stop 80 / start 60: cross stop, go above it, fall back to start
        r = nominal_run();
        r.battery_percent = 7'd70;
        send_run(r);
        r.battery_percent = 7'd80;
        send_run(r);
        r.battery_percent = 7'd90;
        send_run(r);
        r.write_fail = 1'b1;
        send_run(r);
        r.write_fail      = 1'b0;
        r.battery_percent = 7'd60;
        send_run(r);
        soc_walk = 75;
      end

      repeat (RUNS_PER_PHASE) send_run(random_run());
    end

    wait_idle();
    if (board.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
